// ===== hw/rtl/jdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdq_pkg
// Shared types and constants of the joystick direction queue.
// ----------------------------------------------------------------------------
package jdq_pkg;

  // Kind of an input beat, carried in s_tuser.
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned MoveW   = 4;
  localparam int unsigned CountW  = 4;

  // Scaled products: 13 * 1023 still fits in 14 bits.
  localparam int unsigned ProdW = 14;

  // Thresholds in tenths: 1.1 for diagonals, 1.3 for straight moves.
  localparam logic [3:0] Ten      = 4'd10;
  localparam logic [3:0] Diag     = 4'd11;
  localparam logic [3:0] Straight = 4'd13;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegXRest       = 2'd0;
  localparam logic [1:0] RegYRest       = 2'd1;
  localparam logic [1:0] RegRepeatTicks = 2'd2;

  localparam logic [SampleW-1:0] XRestReset       = 10'd512;
  localparam logic [SampleW-1:0] YRestReset       = 10'd512;
  localparam logic [TicksW-1:0]  RepeatTicksReset = 16'd250;
  localparam logic [TicksW-1:0]  TicksMax         = 16'hFFFF;

  // Move codes.
  localparam logic [MoveW-1:0] MoveNone      = 4'd0;
  localparam logic [MoveW-1:0] MoveUpLeft    = 4'd1;
  localparam logic [MoveW-1:0] MoveUpRight   = 4'd2;
  localparam logic [MoveW-1:0] MoveDownLeft  = 4'd3;
  localparam logic [MoveW-1:0] MoveDownRight = 4'd4;
  localparam logic [MoveW-1:0] MoveUp        = 4'd5;
  localparam logic [MoveW-1:0] MoveLeft      = 4'd6;
  localparam logic [MoveW-1:0] MoveRight     = 4'd7;
  localparam logic [MoveW-1:0] MoveDown      = 4'd8;

endpackage
`default_nettype wire

// ===== hw/rtl/joystick_direction_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_direction_queue
// Eight-direction joystick quantizer with auto-repeat and a move queue.
// ----------------------------------------------------------------------------
// Every input beat (sample, pop, clear or tick) produces exactly one output
// beat. The block takes one beat per cycle while m_tready stays high or the
// output register is empty: a beat is classified and applied to the queue
// state in the cycle it is accepted, and its result appears on the output
// register in the next cycle. The move queue is a small memory with one
// write and one registered read per cycle, and the read data is registered
// together with the rest of the output beat. The move queue needs no
// clearing after reset. Configuration writes are taken at any edge with
// cfg_wen high and must only happen while the block is idle.
module joystick_direction_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: index 0 x_rest, 1 y_rest, 2 repeat_ticks.
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [9:0] x_sample, [19:10] y_sample, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] func
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [3:0] move_code, [7:4] queue_count,
                                      // [8] accepted, rest zero
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(QUEUE_DEPTH);

  // Configuration registers.
  logic [jdq_pkg::SampleW-1:0] x_rest;
  logic [jdq_pkg::SampleW-1:0] y_rest;
  logic [jdq_pkg::TicksW-1:0]  repeat_ticks;

  // Queue and timer state.
  logic [jdq_pkg::MoveW-1:0] move_fifo [QUEUE_DEPTH];
  logic [IdxW-1:0]           fifo_head;
  logic [CntW-1:0]           fifo_count;
  logic [jdq_pkg::TicksW-1:0] ticks_since_move;

  logic [IdxW-1:0]            fifo_head_next;
  logic [CntW-1:0]            fifo_count_next;
  logic [jdq_pkg::TicksW-1:0] ticks_since_move_next;

  // Output register.
  logic                      out_valid;
  logic                      out_pop;
  logic [jdq_pkg::MoveW-1:0] rd_data;
  logic [CntW-1:0]           out_count;
  logic                      out_acc;

  logic                        s_fire;
  jdq_pkg::func_t              func;
  logic [jdq_pkg::SampleW-1:0] x_sample;
  logic [jdq_pkg::SampleW-1:0] y_sample;

  logic [jdq_pkg::ProdW-1:0] x10, x11, x13, y10, y11, y13;
  logic [jdq_pkg::ProdW-1:0] rx10, rx11, rx13, ry10, ry11, ry13;
  logic y_hi_d, y_lo_d, x_hi_d, x_lo_d, y_hi_s, y_lo_s, x_hi_s, x_lo_s;
  logic [jdq_pkg::MoveW-1:0] move;

  logic            acc;
  logic            pop_hit;
  logic            wr_en;
  logic [SumW-1:0] slot_sum;
  logic [IdxW-1:0] wr_slot;

  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign func     = jdq_pkg::func_t'(s_tuser[1:0]);
  assign x_sample = s_tdata[9:0];
  assign y_sample = s_tdata[19:10];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_rest       <= jdq_pkg::XRestReset;
      y_rest       <= jdq_pkg::YRestReset;
      repeat_ticks <= jdq_pkg::RepeatTicksReset;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        jdq_pkg::RegXRest:       x_rest       <= cfg_wdata[9:0];
        jdq_pkg::RegYRest:       y_rest       <= cfg_wdata[9:0];
        jdq_pkg::RegRepeatTicks: repeat_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scaled comparisons against the rest values.
  always_comb begin
    x10  = jdq_pkg::ProdW'(x_sample) * jdq_pkg::ProdW'(jdq_pkg::Ten);
    x11  = jdq_pkg::ProdW'(x_sample) * jdq_pkg::ProdW'(jdq_pkg::Diag);
    x13  = jdq_pkg::ProdW'(x_sample) * jdq_pkg::ProdW'(jdq_pkg::Straight);
    y10  = jdq_pkg::ProdW'(y_sample) * jdq_pkg::ProdW'(jdq_pkg::Ten);
    y11  = jdq_pkg::ProdW'(y_sample) * jdq_pkg::ProdW'(jdq_pkg::Diag);
    y13  = jdq_pkg::ProdW'(y_sample) * jdq_pkg::ProdW'(jdq_pkg::Straight);
    rx10 = jdq_pkg::ProdW'(x_rest) * jdq_pkg::ProdW'(jdq_pkg::Ten);
    rx11 = jdq_pkg::ProdW'(x_rest) * jdq_pkg::ProdW'(jdq_pkg::Diag);
    rx13 = jdq_pkg::ProdW'(x_rest) * jdq_pkg::ProdW'(jdq_pkg::Straight);
    ry10 = jdq_pkg::ProdW'(y_rest) * jdq_pkg::ProdW'(jdq_pkg::Ten);
    ry11 = jdq_pkg::ProdW'(y_rest) * jdq_pkg::ProdW'(jdq_pkg::Diag);
    ry13 = jdq_pkg::ProdW'(y_rest) * jdq_pkg::ProdW'(jdq_pkg::Straight);

    y_hi_d = y10 >= ry11;
    y_lo_d = y11 <= ry10;
    x_hi_d = x10 >= rx11;
    x_lo_d = x11 <= rx10;
    y_hi_s = y10 >= ry13;
    x_hi_s = x10 >= rx13;
    x_lo_s = x13 <= rx10;
    y_lo_s = y13 <= ry10;

    priority if (y_hi_d && x_hi_d) move = jdq_pkg::MoveUpLeft;
    else if (y_hi_d && x_lo_d)     move = jdq_pkg::MoveUpRight;
    else if (y_lo_d && x_hi_d)     move = jdq_pkg::MoveDownLeft;
    else if (y_lo_d && x_lo_d)     move = jdq_pkg::MoveDownRight;
    else if (y_hi_s)               move = jdq_pkg::MoveUp;
    else if (x_hi_s)               move = jdq_pkg::MoveLeft;
    else if (x_lo_s)               move = jdq_pkg::MoveRight;
    else if (y_lo_s)               move = jdq_pkg::MoveDown;
    else                           move = jdq_pkg::MoveNone;
  end

  // Tail slot is head plus count, wrapped once at the queue depth.
  always_comb begin
    slot_sum = SumW'(fifo_head) + SumW'(fifo_count);
    if (slot_sum >= DepthSum) begin
      slot_sum = slot_sum - DepthSum;
    end
    wr_slot = slot_sum[IdxW-1:0];
  end

  always_comb begin
    fifo_head_next        = fifo_head;
    fifo_count_next       = fifo_count;
    ticks_since_move_next = ticks_since_move;
    acc                   = 1'b0;
    pop_hit               = 1'b0;
    unique case (func)
      jdq_pkg::FUNC_SAMPLE: begin
        if (ticks_since_move >= repeat_ticks && fifo_count != FullCnt &&
            move != jdq_pkg::MoveNone) begin
          acc                   = 1'b1;
          fifo_count_next       = fifo_count + 1'b1;
          ticks_since_move_next = '0;
        end
      end
      jdq_pkg::FUNC_POP: begin
        if (fifo_count != '0) begin
          pop_hit         = 1'b1;
          fifo_head_next  = (fifo_head == LastIdx) ? '0 : fifo_head + 1'b1;
          fifo_count_next = fifo_count - 1'b1;
        end
      end
      jdq_pkg::FUNC_CLEAR: begin
        fifo_head_next  = '0;
        fifo_count_next = '0;
      end
      jdq_pkg::FUNC_TICK: begin
        if (ticks_since_move != jdq_pkg::TicksMax) begin
          ticks_since_move_next = ticks_since_move + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_en = s_fire && acc;

  // Move memory: one write at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      move_fifo[wr_slot] <= move;
    end
    if (s_fire) begin
      rd_data <= move_fifo[fifo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head        <= '0;
      fifo_count       <= '0;
      ticks_since_move <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (s_fire) begin
        fifo_head        <= fifo_head_next;
        fifo_count       <= fifo_count_next;
        ticks_since_move <= ticks_since_move_next;
        out_valid        <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_pop   <= pop_hit;
      out_count <= fifo_count_next;
      out_acc   <= acc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_acc, jdq_pkg::CountW'(out_count),
                     out_pop ? rd_data : jdq_pkg::MoveNone};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FullCnt)
    else $error("queue count above depth");

  a_acc_no_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[3:0] == jdq_pkg::MoveNone))
    else $error("accepted sample also carries a popped move");

  a_timer_restart: assert property (@(posedge clk) disable iff (rst)
    (s_fire && acc) |=> (ticks_since_move == '0))
    else $error("repeat timer not restarted after a queued move");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (s_fire && func == jdq_pkg::FUNC_CLEAR) |=> (fifo_count == '0 && fifo_head == '0))
    else $error("queue not empty after clear");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s_fire && acc) |=> (fifo_count == $past(fifo_count) + 1'b1))
    else $error("queued move did not raise the count");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joystick direction queue. A scoreboard class
// tracks the rest values, the repeat timer and the move queue, and predicts
// one result for every input beat. The input and output streams stall in
// random bursts. The rest values and the repeat interval are changed between
// phases while the block is drained.
// ----------------------------------------------------------------------------

typedef struct {
  logic [jdq_pkg::MoveW-1:0]  code;
  logic [jdq_pkg::CountW-1:0] count;
  logic                       acc;
} queue_result_t;

class move_scoreboard;
  localparam int unsigned QueueDepth = 8;

  logic [jdq_pkg::SampleW-1:0] x_rest;
  logic [jdq_pkg::SampleW-1:0] y_rest;
  logic [jdq_pkg::TicksW-1:0]  repeat_ticks;
  logic [jdq_pkg::MoveW-1:0]   moves [QueueDepth];
  int unsigned                 head;
  int unsigned                 count;
  logic [jdq_pkg::TicksW-1:0]  ticks;
  queue_result_t               expected_q [$];
  int                          errors;

  function new();
    x_rest       = jdq_pkg::XRestReset;
    y_rest       = jdq_pkg::YRestReset;
    repeat_ticks = jdq_pkg::RepeatTicksReset;
    head         = 0;
    count        = 0;
    ticks        = '0;
    errors       = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      jdq_pkg::RegXRest:       x_rest = val[jdq_pkg::SampleW-1:0];
      jdq_pkg::RegYRest:       y_rest = val[jdq_pkg::SampleW-1:0];
      jdq_pkg::RegRepeatTicks: repeat_ticks = val;
      default: ;
    endcase
  endfunction

  function logic [jdq_pkg::MoveW-1:0] direction_of(logic [jdq_pkg::SampleW-1:0] x,
                                                   logic [jdq_pkg::SampleW-1:0] y);
    int unsigned xv, yv, rx, ry;
    bit y_hi, y_lo, x_hi, x_lo;
    xv = x;
    yv = y;
    rx = x_rest;
    ry = y_rest;
    y_hi = (10 * yv >= 11 * ry);
    y_lo = (11 * yv <= 10 * ry);
    x_hi = (10 * xv >= 11 * rx);
    x_lo = (11 * xv <= 10 * rx);
    if (y_hi && x_hi) return jdq_pkg::MoveUpLeft;
    if (y_hi && x_lo) return jdq_pkg::MoveUpRight;
    if (y_lo && x_hi) return jdq_pkg::MoveDownLeft;
    if (y_lo && x_lo) return jdq_pkg::MoveDownRight;
    if (10 * yv >= 13 * ry) return jdq_pkg::MoveUp;
    if (10 * xv >= 13 * rx) return jdq_pkg::MoveLeft;
    if (13 * xv <= 10 * rx) return jdq_pkg::MoveRight;
    if (13 * yv <= 10 * ry) return jdq_pkg::MoveDown;
    return jdq_pkg::MoveNone;
  endfunction

  function void note_beat(jdq_pkg::func_t f, logic [jdq_pkg::SampleW-1:0] x,
                          logic [jdq_pkg::SampleW-1:0] y);
    queue_result_t r;
    logic [jdq_pkg::MoveW-1:0] mv;
    r.code = jdq_pkg::MoveNone;
    r.acc  = 1'b0;
    case (f)
      jdq_pkg::FUNC_SAMPLE: begin
        // A full queue or a running repeat timer drops the move silently.
        if (ticks >= repeat_ticks && count < QueueDepth) begin
          mv = direction_of(x, y);
          if (mv != jdq_pkg::MoveNone) begin
            moves[(head + count) % QueueDepth] = mv;
            count++;
            ticks = '0;
            r.acc = 1'b1;
          end
        end
      end
      jdq_pkg::FUNC_POP: begin
        if (count > 0) begin
          r.code = moves[head];
          head = (head + 1) % QueueDepth;
          count--;
        end
      end
      jdq_pkg::FUNC_CLEAR: begin
        head  = 0;
        count = 0;
      end
      default: begin
        if (ticks != jdq_pkg::TicksMax) ticks++;
      end
    endcase
    r.count = count[jdq_pkg::CountW-1:0];
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [15:0] beat);
    queue_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: output beat %h with no result pending", $time, beat);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (beat[3:0] !== e.code) begin
      $display("%0t: move_code expected %0d actual %0d", $time, e.code, beat[3:0]);
      errors++;
    end
    if (beat[7:4] !== e.count) begin
      $display("%0t: queue_count expected %0d actual %0d", $time, e.count, beat[7:4]);
      errors++;
    end
    if (beat[8] !== e.acc) begin
      $display("%0t: accepted expected %0d actual %0d", $time, e.acc, beat[8]);
      errors++;
    end
    if (beat[15:9] !== 7'd0) begin
      $display("%0t: padding expected 0 actual %h", $time, beat[15:9]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [9:0] x_sample, [19:10] y_sample, rest zero
  logic [1:0]  s_tuser;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [3:0] move_code, [7:4] queue_count, [8] accepted, rest zero

  move_scoreboard sb;
  bit idling_on;
  int stall_left;
  int cycles;

  joystick_direction_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_beat(jdq_pkg::func_t'(s_tuser), s_tdata[9:0], s_tdata[19:10]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_beat(jdq_pkg::func_t f, logic [jdq_pkg::SampleW-1:0] x,
                           logic [jdq_pkg::SampleW-1:0] y);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'd0, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Axis reading: uniform, near a class threshold of the current rest value, at an end of the range, or near rest.
  function automatic logic [jdq_pkg::SampleW-1:0] axis_value(
      logic [jdq_pkg::SampleW-1:0] rest);
    int v;
    int r;
    r = rest;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1023);
      1: begin
        case ($urandom_range(0, 3))
          0: v = r * 11 / 10;
          1: v = r * 10 / 11;
          2: v = r * 13 / 10;
          default: v = r * 10 / 13;
        endcase
        v = v + $urandom_range(0, 2) - 1;
      end
      2: v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
      default: v = r + $urandom_range(0, 40) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[jdq_pkg::SampleW-1:0];
  endfunction

  task automatic random_phase(int n_items);
    int sel;
    jdq_pkg::func_t f;
    repeat (n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) f = jdq_pkg::FUNC_SAMPLE;
      else if (sel < 70) f = jdq_pkg::FUNC_TICK;
      else if (sel < 92) f = jdq_pkg::FUNC_POP;
      else f = jdq_pkg::FUNC_CLEAR;
      send_beat(f, axis_value(sb.x_rest), axis_value(sb.y_rest));
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst        = 1'b1;
    cfg_wen    = 1'b0;
    cfg_addr   = jdq_pkg::RegXRest;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = jdq_pkg::FUNC_SAMPLE;
    m_tready   = 1'b0;
    stall_left = 0;
    cycles     = 0;
    idling_on  = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the first move waits for the full repeat interval.
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023);
    repeat (249) send_beat(jdq_pkg::FUNC_TICK, 10'($urandom), 10'($urandom));
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023);
    send_beat(jdq_pkg::FUNC_TICK, 10'd0, 10'd0);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023);
    send_beat(jdq_pkg::FUNC_POP, 10'd0, 10'd0);
    drain();

    write_reg(jdq_pkg::RegRepeatTicks, 16'd0);
    write_reg(jdq_pkg::RegXRest, 16'd512);
    write_reg(jdq_pkg::RegYRest, 16'd512);
    send_beat(jdq_pkg::FUNC_CLEAR, 10'd0, 10'd0);
    send_beat(jdq_pkg::FUNC_POP, 10'd0, 10'd0);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd1023);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd0, 10'd1023);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd0);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd0, 10'd0);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd512, 10'd512);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd512, 10'd1023);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd1023, 10'd512);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd0, 10'd512);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd512, 10'd0);
    // The queue is full now, so this diagonal is dropped.
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd564, 10'd564);
    repeat (9) send_beat(jdq_pkg::FUNC_POP, 10'd1023, 10'd1023);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd563, 10'd563);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd564, 10'd564);
    send_beat(jdq_pkg::FUNC_SAMPLE, 10'd512, 10'd666);
    send_beat(jdq_pkg::FUNC_CLEAR, 10'd1023, 10'd1023);
    send_beat(jdq_pkg::FUNC_POP, 10'd0, 10'd0);
    send_beat(jdq_pkg::FUNC_TICK, 10'd0, 10'd0);
    drain();

    write_reg(jdq_pkg::RegXRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegYRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegRepeatTicks, 16'd0);
    random_phase(30);

    write_reg(jdq_pkg::RegXRest, 16'd0);
    write_reg(jdq_pkg::RegYRest, 16'd1023);
    write_reg(jdq_pkg::RegRepeatTicks, 16'd1);
    random_phase(30);

    write_reg(jdq_pkg::RegXRest, 16'd1023);
    write_reg(jdq_pkg::RegYRest, 16'd0);
    write_reg(jdq_pkg::RegRepeatTicks, 16'd2);
    random_phase(30);

    write_reg(jdq_pkg::RegXRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegYRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegRepeatTicks, 16'($urandom_range(0, 3)));
    random_phase(30);

    write_reg(jdq_pkg::RegXRest, 16'($urandom_range(300, 700)));
    write_reg(jdq_pkg::RegYRest, 16'($urandom_range(300, 700)));
    write_reg(jdq_pkg::RegRepeatTicks, 16'd0);
    random_phase(30);

    idling_on = 1'b0;
    write_reg(jdq_pkg::RegXRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegYRest, 16'($urandom_range(0, 1023)));
    write_reg(jdq_pkg::RegRepeatTicks, 16'd1);
    random_phase(30);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
